FILE: sv/pirh_pkg.sv
// shared types and constants for the rectangle hit test block
package pirh_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int PNUM_W      = 16;
    localparam int FIG_W       = 5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        RES_ADD_OK        = 2'd0,
        RES_ADD_FULL      = 2'd1,
        RES_CONTAINED     = 2'd2,
        RES_NOT_CONTAINED = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN
    } state_t;

    typedef struct packed {
        op_t    operation;
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t point_x;
        coord_t point_y;
    } in_item_t;

    typedef struct packed {
        result_kind_t            result_kind;
        logic [PNUM_W-1:0]       point_number;
        logic [FIG_W-1:0]        figure_number;
        logic                    last;
    } out_item_t;

    typedef struct packed {
        coord_t x_low;
        coord_t x_high;
        coord_t y_low;
        coord_t y_high;
    } rect_t;

endpackage

FILE: sv/pirh_rect_mem.sv
// rectangle table memory, one write port and one registered read port
module pirh_rect_mem
    import pirh_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rect_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output rect_t         rd_data
);

    rect_t mem [DEPTH];
    rect_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/pirh_cmp_unit.sv
// inclusive range check of one point against one rectangle
module pirh_cmp_unit
    import pirh_pkg::*;
(
    input  rect_t  rect,
    input  coord_t point_x,
    input  coord_t point_y,
    output logic   hit
);

    logic in_x;
    logic in_y;

    assign in_x = (point_x >= rect.x_low) && (point_x <= rect.x_high);
    assign in_y = (point_y >= rect.y_low) && (point_y <= rect.y_high);
    assign hit  = in_x && in_y;

endmodule

FILE: sv/pirh_ctrl.sv
// sequencer: item capture, table scan, counters and result register
module pirh_ctrl
    import pirh_pkg::*;
#(
    parameter int MAX_RECTS = 16,
    parameter int AW        = 4,
    parameter int CW        = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  in_item_t      item,
    output in_item_t      item_q,
    input  logic          hit,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [AW-1:0] rd_addr,
    output logic          result_valid,
    input  logic          result_stall,
    output out_item_t     result
);

    state_t            state_reg, state_next;
    in_item_t          item_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [PNUM_W-1:0] qnum_reg, qnum_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [FIG_W-1:0]  pend_fig_reg, pend_fig_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic          accept;
    logic          out_free;
    logic          full;
    logic          at_end;
    logic          push;
    logic          advance;
    logic          done;
    out_item_t     push_item;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] count_inc;

    assign accept    = item_valid && !item_stall;
    assign out_free  = !out_valid_reg || !result_stall;
    assign full      = (count_reg == CW'(MAX_RECTS));
    assign at_end    = (idx_reg == count_reg);
    assign idx_inc   = idx_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;

    // output decode
    always_comb
    begin
        item_stall = (state_reg != S_IDLE);
        push       = 1'b0;
        advance    = 1'b0;
        done       = 1'b0;
        wr_en      = 1'b0;
        push_item  = '0;
        case (state_reg)
            S_IDLE:
            begin
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    done = 1'b1;
                    push_item.last = 1'b1;
                    if (full)
                    begin
                        push_item.result_kind = RES_ADD_FULL;
                    end
                    else
                    begin
                        wr_en                   = 1'b1;
                        push_item.result_kind   = RES_ADD_OK;
                        push_item.figure_number = FIG_W'(count_inc);
                    end
                end
            end
            S_SCAN:
            begin
                push_item.point_number = qnum_reg;
                if (at_end)
                begin
                    // flush the held hit as the final one, or report a miss
                    if (out_free)
                    begin
                        push           = 1'b1;
                        done           = 1'b1;
                        push_item.last = 1'b1;
                        if (pend_valid_reg)
                        begin
                            push_item.result_kind   = RES_CONTAINED;
                            push_item.figure_number = pend_fig_reg;
                        end
                        else
                        begin
                            push_item.result_kind = RES_NOT_CONTAINED;
                        end
                    end
                end
                else if (hit && pend_valid_reg)
                begin
                    // a later hit proves the held one is not the last
                    if (out_free)
                    begin
                        push                    = 1'b1;
                        advance                 = 1'b1;
                        push_item.result_kind   = RES_CONTAINED;
                        push_item.figure_number = pend_fig_reg;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.operation == OP_ADD) ? S_ADD : S_SCAN;
                end
            end
            S_ADD,
            S_SCAN:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        qnum_next       = qnum_reg;
        pend_valid_next = pend_valid_reg;
        pend_fig_next   = pend_fig_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;

        if (accept)
        begin
            idx_next        = '0;
            pend_valid_next = 1'b0;
            if (item.operation == OP_QUERY)
            begin
                qnum_next = qnum_reg + 1'b1;
            end
        end
        if (wr_en)
        begin
            count_next = count_inc;
        end
        if (advance)
        begin
            idx_next = idx_inc;
            if (hit)
            begin
                pend_valid_next = 1'b1;
                pend_fig_next   = FIG_W'(idx_inc);
            end
        end
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            qnum_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            qnum_reg       <= qnum_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_fig_reg <= pend_fig_next;
        out_reg      <= out_next;
        if (accept)
        begin
            item_reg <= item;
        end
    end

    assign item_q       = item_reg;
    assign wr_addr      = count_reg[AW-1:0];
    assign rd_addr      = idx_next[AW-1:0];
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: sv/point_in_rectangle_hit_test_top.sv
// top level of the point in rectangle hit test block
//
// input channel item/item_valid/item_stall: an item is taken at a rising edge
// with item_valid high and item_stall low. operation OP_ADD stores the
// rectangle spanned by the two corners (bounds sorted per axis), OP_QUERY
// tests point_x/point_y against every stored rectangle, bounds inclusive.
// output channel result/result_valid/result_stall: an add gives one status
// item, a query gives one contained item per hit in table order or a single
// not-contained item; the final item of each input carries last.
// item_stall is high from the accepting edge until the final result of that
// item is loaded into the result register.
// add: the status goes from the add state into the result register once that
// register is free. query: the single compare unit checks one table entry
// per cycle, read from the single read port of the table memory, unless a
// result must wait for a stalled result register; a hit is held back until
// a later hit or the table end so the last one can be flagged. the scan
// covers the stored rectangles (at most MAX_RECTS); a stalled result
// register holds the scan only where a result is to be loaded.
// reset clears the rectangle count, the query counter and the result valid
// flag; table contents are only used below the count and need no clearing.
module point_in_rectangle_hit_test_top
    import pirh_pkg::*;
#(
    parameter int MAX_RECTS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // table index and count widths
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW = $clog2(MAX_RECTS + 1);

    in_item_t      item_q;
    logic          hit;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    rect_t         wr_rect;
    rect_t         rd_rect;

    // per-axis ordering of the corners into low and high bounds
    always_comb
    begin
        if (item_q.corner_a_x < item_q.corner_b_x)
        begin
            wr_rect.x_low  = item_q.corner_a_x;
            wr_rect.x_high = item_q.corner_b_x;
        end
        else
        begin
            wr_rect.x_low  = item_q.corner_b_x;
            wr_rect.x_high = item_q.corner_a_x;
        end
        if (item_q.corner_a_y < item_q.corner_b_y)
        begin
            wr_rect.y_low  = item_q.corner_a_y;
            wr_rect.y_high = item_q.corner_b_y;
        end
        else
        begin
            wr_rect.y_low  = item_q.corner_b_y;
            wr_rect.y_high = item_q.corner_a_y;
        end
    end

    // sequencer, counters and result register
    pirh_ctrl #(
        .MAX_RECTS (MAX_RECTS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .item_q       (item_q),
        .hit          (hit),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // rectangle table
    pirh_rect_mem #(
        .DEPTH (MAX_RECTS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rect),
        .rd_addr (rd_addr),
        .rd_data (rd_rect)
    );

    // one entry checked per cycle against the captured point, unless a result waits on a stalled result register
    pirh_cmp_unit u_cmp (
        .rect    (rd_rect),
        .point_x (item_q.point_x),
        .point_y (item_q.point_y),
        .hit     (hit)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the point in rectangle hit test block
module testbench;
    import pirh_pkg::*;

    localparam int MAX_RECTS    = 16;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 98;

    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam coord_t C_MAX = 32'sh7fff_ffff;
    localparam coord_t ONE   = 32'sh0001_0000;
    // hotspot: most random rectangles are built around this point so that
    // queries there pile up many hits
    localparam coord_t HOT_X = 32'sh0005_0000;
    localparam coord_t HOT_Y = 32'sh0005_0000;

    // one pending input item and the idle percentages of its stretch
    typedef struct {
        in_item_t item;
        int       tx_idle;
        int       rx_idle;
    } send_slot_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    // items still to be driven, filled once at time zero
    send_slot_t items_to_send[$];
    // results the hit test must still produce, oldest first
    out_item_t  due_results[$];

    // predictor state: stored rectangles, their count and the query counter
    rect_t             known_rects[MAX_RECTS];
    int unsigned       known_count = 0;
    logic [PNUM_W-1:0] query_seq   = '0;

    // rectangles as the stimulus generator sees them, used only to aim queries
    rect_t gen_rects[$];

    int          rx_idle_pct  = 0;
    bit          item_taken   = 1'b0;
    int          mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned taken_count  = 0;
    int unsigned queued_count = 0;

    point_in_rectangle_hit_test_top #(
        .MAX_RECTS (MAX_RECTS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // inclusive range test on signed fixed point values
    function automatic bit within_span(coord_t lo, coord_t hi, coord_t p);
        return (p >= lo) && (p <= hi);
    endfunction

    // uniform value between two signed bounds, both included
    function automatic coord_t pick_between(coord_t lo, coord_t hi);
        longint span;
        span = longint'(hi) - longint'(lo);
        return coord_t'(longint'(lo) + (longint'({$urandom}) % (span + 1)));
    endfunction

    // work out the results of one accepted item and update the table
    task automatic model_hit_test(input in_item_t it);
        coord_t    ax;
        coord_t    ay;
        coord_t    bx;
        coord_t    by;
        rect_t     r;
        out_item_t o;
        int        hits;
        ax   = it.corner_a_x;
        ay   = it.corner_a_y;
        bx   = it.corner_b_x;
        by   = it.corner_b_y;
        hits = 0;
        o    = '0;
        if (it.operation == OP_ADD) begin
            o.last = 1'b1;
            if (known_count >= MAX_RECTS) begin
                // full table: nothing stored, figure stays zero
                o.result_kind = RES_ADD_FULL;
            end
            else begin
                r.x_low  = (ax < bx) ? ax : bx;
                r.x_high = (ax < bx) ? bx : ax;
                r.y_low  = (ay < by) ? ay : by;
                r.y_high = (ay < by) ? by : ay;
                known_rects[known_count] = r;
                known_count++;
                o.result_kind   = RES_ADD_OK;
                o.figure_number = FIG_W'(known_count);
            end
            due_results.push_back(o);
        end
        else begin
            query_seq++;
            for (int i = 0; i < known_count; i++) begin
                if (within_span(known_rects[i].x_low, known_rects[i].x_high, it.point_x) &&
                    within_span(known_rects[i].y_low, known_rects[i].y_high, it.point_y)) begin
                    o.result_kind   = RES_CONTAINED;
                    o.point_number  = query_seq;
                    o.figure_number = FIG_W'(i + 1);
                    o.last          = 1'b0;
                    due_results.push_back(o);
                    hits++;
                end
            end
            if (hits == 0) begin
                o.result_kind   = RES_NOT_CONTAINED;
                o.point_number  = query_seq;
                o.figure_number = '0;
                o.last          = 1'b1;
                due_results.push_back(o);
            end
            else begin
                due_results[$].last = 1'b1;
            end
        end
    endtask

    // compare one accepted result with the oldest awaited one
    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (due_results.size() == 0) begin
            $error("result with nothing awaited: kind %0d point %0d figure %0d last %0d",
                   got.result_kind, got.point_number, got.figure_number, got.last);
            mismatches++;
        end
        else begin
            want = due_results.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
                mismatches++;
            end
            if (got.point_number !== want.point_number) begin
                $error("point_number: expected %0d, got %0d",
                       want.point_number, got.point_number);
                mismatches++;
            end
            if (got.figure_number !== want.figure_number) begin
                $error("figure_number: expected %0d, got %0d",
                       want.figure_number, got.figure_number);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    task automatic queue_item(input op_t op, input coord_t ax, input coord_t ay,
                              input coord_t bx, input coord_t by, input coord_t px,
                              input coord_t py, input int tx, input int rx);
        send_slot_t s;
        s.item.operation  = op;
        s.item.corner_a_x = ax;
        s.item.corner_a_y = ay;
        s.item.corner_b_x = bx;
        s.item.corner_b_y = by;
        s.item.point_x    = px;
        s.item.point_y    = py;
        s.tx_idle         = tx;
        s.rx_idle         = rx;
        items_to_send.push_back(s);
    endtask

    // add item; the unused point fields carry random noise
    task automatic queue_rect(input coord_t ax, input coord_t ay, input coord_t bx,
                              input coord_t by, input int tx, input int rx);
        rect_t r;
        r.x_low  = (ax < bx) ? ax : bx;
        r.x_high = (ax < bx) ? bx : ax;
        r.y_low  = (ay < by) ? ay : by;
        r.y_high = (ay < by) ? by : ay;
        if (gen_rects.size() < MAX_RECTS)
            gen_rects.push_back(r);
        queue_item(OP_ADD, ax, ay, bx, by, coord_t'($urandom), coord_t'($urandom), tx, rx);
    endtask

    // query item; the unused corner fields carry random noise
    task automatic queue_point(input coord_t px, input coord_t py, input int tx, input int rx);
        queue_item(OP_QUERY, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                   coord_t'($urandom), px, py, tx, rx);
    endtask

    // driver: a new item is offered at the falling edge once the previous
    // one has been taken; a held item never changes while stalled
    always @(negedge clk)
    begin
        if (!rst_n) begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_taken) begin
            item_taken = 1'b0;
            if (items_to_send.size() > 0 &&
                $urandom_range(99) >= items_to_send[0].tx_idle) begin
                item        <= items_to_send[0].item;
                rx_idle_pct  = items_to_send[0].rx_idle;
                item_valid  <= 1'b1;
                void'(items_to_send.pop_front());
            end
            else begin
                item_valid <= 1'b0;
            end
        end
        // the receiver stalls at the rate of the stretch now being driven
        result_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
    end

    // monitor: both handshakes are sampled at the rising edge; the item is
    // modeled before it is counted so the end test never sees a gap
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n) begin
            if (item_valid && !item_stall) begin
                model_hit_test(item);
                taken_count++;
                item_taken = 1'b1;
            end
            if (result_valid && !result_stall)
                check_result(result);
        end
    end

    initial
    begin : stimulus
        int     tx;
        int     rx;
        int     sel;
        int     pick;
        bit     timed_out;
        coord_t xl;
        coord_t xh;
        coord_t yl;
        coord_t yh;
        coord_t px;
        coord_t py;

        rst_n = 1'b0;

        // directed part: extreme corners, reversed corners, degenerate
        // rectangles, then points on and just beside their edges
        queue_rect(C_MIN, C_MIN, C_MAX, C_MAX, 13, 81);
        queue_rect(100 * ONE, 50 * ONE, -20 * ONE, -70 * ONE, 13, 81);
        queue_rect(HOT_X, HOT_Y, HOT_X, HOT_Y, 13, 81);
        queue_rect(-3 * ONE, 40 * ONE, -3 * ONE, 32'sd0, 13, 81);
        queue_point(C_MIN, C_MIN, 13, 81);
        queue_point(C_MAX, C_MAX, 13, 81);
        queue_point(HOT_X, HOT_Y, 13, 81);
        queue_point(HOT_X + 1, HOT_Y, 13, 81);
        queue_point(100 * ONE, -70 * ONE, 13, 81);
        queue_point(100 * ONE + 1, 32'sd0, 13, 81);
        queue_point(-3 * ONE, 40 * ONE, 13, 81);
        queue_point(-3 * ONE - 1, 20 * ONE, 13, 81);

        // random part: about a quarter adds, so the table fills and later
        // adds are turned away; queries are mostly aimed at stored rectangles
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k < 35) begin
                tx = 13;
                rx = 81;
            end
            else if (k < 75) begin
                tx = 81;
                rx = 13;
            end
            else begin
                tx = 0;
                rx = 0;
            end
            if ($urandom_range(99) < 25) begin
                sel = $urandom_range(99);
                xl  = HOT_X - coord_t'($urandom_range(0, 1 << 20));
                xh  = HOT_X + coord_t'($urandom_range(0, 1 << 20));
                yl  = HOT_Y - coord_t'($urandom_range(0, 1 << 20));
                yh  = HOT_Y + coord_t'($urandom_range(0, 1 << 20));
                if (sel < 20) begin
                    // anywhere in the whole plane
                    xl = coord_t'($urandom);
                    xh = coord_t'($urandom);
                    yl = coord_t'($urandom);
                    yh = coord_t'($urandom);
                end
                else if (sel < 35) begin
                    // zero width on one axis
                    if ($urandom_range(1))
                        xh = xl;
                    else
                        yh = yl;
                end
                // corner order varies per axis
                case ($urandom_range(2))
                    0: queue_rect(xl, yl, xh, yh, tx, rx);
                    1: queue_rect(xh, yl, xl, yh, tx, rx);
                    default: queue_rect(xh, yh, xl, yl, tx, rx);
                endcase
            end
            else begin
                sel  = $urandom_range(9);
                pick = $urandom_range(gen_rects.size() - 1);
                px   = coord_t'($urandom);
                py   = coord_t'($urandom);
                if (sel < 2) begin
                    px = HOT_X;
                    py = HOT_Y;
                end
                else if (sel < 5) begin
                    px = pick_between(gen_rects[pick].x_low, gen_rects[pick].x_high);
                    py = pick_between(gen_rects[pick].y_low, gen_rects[pick].y_high);
                end
                else if (sel < 7) begin
                    // exactly on a corner
                    px = $urandom_range(1) ? gen_rects[pick].x_low : gen_rects[pick].x_high;
                    py = $urandom_range(1) ? gen_rects[pick].y_low : gen_rects[pick].y_high;
                end
                else if (sel < 8) begin
                    // one step outside a single edge
                    px = pick_between(gen_rects[pick].x_low, gen_rects[pick].x_high);
                    py = pick_between(gen_rects[pick].y_low, gen_rects[pick].y_high);
                    case ($urandom_range(3))
                        0: px = gen_rects[pick].x_low - 1;
                        1: px = gen_rects[pick].x_high + 1;
                        2: py = gen_rects[pick].y_low - 1;
                        default: py = gen_rects[pick].y_high + 1;
                    endcase
                end
                queue_point(px, py, tx, rx);
            end
        end
        queued_count = items_to_send.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // run until every item is taken and every result has arrived
        while (!((taken_count == queued_count && due_results.size() == 0) ||
                 cycle_count >= CYCLE_LIMIT))
            @(negedge clk);
        timed_out = (cycle_count >= CYCLE_LIMIT);

        if (timed_out) begin
            $display("point_in_rectangle_hit_test_top regression: fail");
        end
        else begin
            // give any stray result time to show up
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (mismatches == 0)
                $display("point_in_rectangle_hit_test_top regression: pass");
            else
                $display("point_in_rectangle_hit_test_top regression: fail");
        end
        $finish;
    end

endmodule
